// ===== rtl/drwm_pkg.sv =====
// drwm_pkg: shared constants, register indexes and controller states
// for the delay running and window mean block; no dependencies
package drwm_pkg;

	localparam int MAX_WINDOW = 64;
	localparam int SLOT_W     = $clog2(MAX_WINDOW);
	localparam int FILL_W     = $clog2(MAX_WINDOW + 1);
	localparam int SAMPLE_W   = 16;
	localparam int COUNT_W    = 32;
	localparam int OFFSET_W   = 24;
	localparam int MEAN_W     = 32;
	localparam int TOTAL_W    = SAMPLE_W + SLOT_W;
	localparam int N_W        = COUNT_W + 1;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	// serial divider geometry, shared by both dividers
	localparam int DIV_NW     = 40;
	localparam int DIV_DW     = 34;
	localparam int DIV_CNT_W  = $clog2(DIV_NW + 1);

	localparam logic [MEAN_W-1:0] MEAN_ONE = 32'h0001_0000;
	localparam logic [MEAN_W-1:0] MEAN_MAX = 32'hFFFF_FFFF;

	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COUNT_OFFSET = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_INITIAL_MEAN = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PUSH,
		ST_START,
		ST_DIV,
		ST_FIN
	} ctrl_state_t;

endpackage

// ===== rtl/drwm_if.sv =====
// drwm_if: valid/ready channel interfaces for sample and result beats
// depends on drwm_pkg for field widths
interface drwm_in_if;
	logic                            valid;
	logic                            ready;
	logic [drwm_pkg::SAMPLE_W-1:0]   delay_sample;
	logic [drwm_pkg::COUNT_W-1:0]    expanded_count;

	modport source (output valid, output delay_sample, output expanded_count, input ready);
	modport sink (input valid, input delay_sample, input expanded_count, output ready);
endinterface

interface drwm_out_if;
	logic                            valid;
	logic                            ready;
	logic [drwm_pkg::MEAN_W-1:0]     window_mean;
	logic [drwm_pkg::MEAN_W-1:0]     total_mean;
	logic                            warming_up;

	modport source (output valid, output window_mean, output total_mean, output warming_up,
		input ready);
	modport sink (input valid, input window_mean, input total_mean, input warming_up,
		output ready);
endinterface

// ===== rtl/drwm_div.sv =====
// drwm_div: bit-serial restoring divider, one quotient bit per cycle
// depends on drwm_pkg for operand widths
module drwm_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [drwm_pkg::DIV_NW-1:0] num,
	input  logic [drwm_pkg::DIV_DW-1:0] den,
	output logic                       busy,
	output logic [drwm_pkg::DIV_NW-1:0] quot
);
	import drwm_pkg::*;

	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DIV_NW-1:0]    shf_q;
	logic [DIV_DW-1:0]    rem_q;
	logic [DIV_DW-1:0]    den_q;
	logic [DIV_DW:0]      rem_sh;
	logic [DIV_DW:0]      rem_diff;
	logic                 take;

	assign rem_sh   = {rem_q, shf_q[DIV_NW-1]};
	assign rem_diff = rem_sh - {1'b0, den_q};
	assign take     = rem_sh >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= DIV_CNT_W'(DIV_NW);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			shf_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (cnt_q != '0) begin
			shf_q <= {shf_q[DIV_NW-2:0], take};
			rem_q <= take ? rem_diff[DIV_DW-1:0] : rem_sh[DIV_DW-1:0];
		end
	end

	assign busy = cnt_q != '0;
	assign quot = shf_q;

endmodule

// ===== rtl/drwm_window.sv =====
// drwm_window: ring of recent delays with running sum and fill count
// depends on drwm_pkg; the ring is a single-port-write, registered-read memory
module drwm_window (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         flush,
	input  logic                         push,
	input  logic [drwm_pkg::FILL_W-1:0]  wsize,
	input  logic [drwm_pkg::SAMPLE_W-1:0] delay,
	output logic [drwm_pkg::TOTAL_W-1:0] total,
	output logic [drwm_pkg::FILL_W-1:0]  fill
);
	import drwm_pkg::*;

	logic [SAMPLE_W-1:0] ring [MAX_WINDOW];
	logic [SAMPLE_W-1:0] rd_q;
	logic [TOTAL_W-1:0]  total_q;
	logic [FILL_W-1:0]   fill_q;
	logic [SLOT_W-1:0]   oldest_q;
	logic                growing;
	logic [FILL_W-1:0]   slot_sum;
	logic [FILL_W-1:0]   slot_wrap;
	logic [FILL_W-1:0]   oldest_inc;
	logic [SLOT_W-1:0]   wr_slot;

	assign growing    = fill_q < wsize;
	assign slot_sum   = {1'b0, oldest_q} + fill_q;
	assign slot_wrap  = (slot_sum >= wsize) ? slot_sum - wsize : slot_sum;
	assign oldest_inc = {1'b0, oldest_q} + 1'b1;
	assign wr_slot    = growing ? slot_wrap[SLOT_W-1:0] : oldest_q;

	// oldest entry is read every cycle; it is stable from accept to push
	always_ff @(posedge clk) begin
		rd_q <= ring[oldest_q];
		if (push) begin
			ring[wr_slot] <= delay;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q  <= '0;
			fill_q   <= '0;
			oldest_q <= '0;
		end else if (flush) begin
			total_q  <= '0;
			fill_q   <= '0;
			oldest_q <= '0;
		end else if (push) begin
			if (growing) begin
				total_q <= total_q + TOTAL_W'(delay);
				fill_q  <= fill_q + 1'b1;
			end else begin
				total_q  <= total_q - TOTAL_W'(rd_q) + TOTAL_W'(delay);
				oldest_q <= (oldest_inc >= wsize) ? '0 : oldest_inc[SLOT_W-1:0];
			end
		end
	end

	assign total = total_q;
	assign fill  = fill_q;

endmodule

// ===== rtl/delay_running_and_window_mean.sv =====
// delay_running_and_window_mean: top level with controller, settings and result register
// depends on drwm_pkg, drwm_if, drwm_div and drwm_window
//
// samples (sink): one beat per delay sample with the current expansion count
// means (source): one beat per sample with window mean, total mean, warm-up flag
// cfg_we/cfg_index/cfg_data: register writes, to be issued only while idle
//   0 window size (flushes the ring), 1 count offset, 2 initial mean (loads mean)
// one sample is in flight at a time: samples.ready is high only when idle
// each sample beat passes through ring update, divider load, the two bit-serial dividers
//   running side by side, and finish before result valid
// the 40-bit serial divide bounds the sample rate; no new sample enters until the last one finishes
// the result register lets a new sample enter while the last result waits;
//   a finished result holds in the controller until the register frees up
// reset clears all settings, the running mean and the ring; no result is valid
module delay_running_and_window_mean (
	input  logic                             clk,
	input  logic                             arst_n,
	drwm_in_if.sink                          samples,
	drwm_out_if.source                       means,
	input  logic                             cfg_we,
	input  logic [drwm_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [drwm_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import drwm_pkg::*;

	ctrl_state_t state_q, state_d;

	logic [FILL_W-1:0]   window_size_q;
	logic [OFFSET_W-1:0] count_offset_q;
	logic [MEAN_W-1:0]   running_mean_q;

	logic [SAMPLE_W-1:0] delay_q;
	logic [N_W-1:0]      n_q;
	logic                warm_q;
	logic                up_q;
	logic [DIV_DW-1:0]   num1_q;
	logic [DIV_DW-1:0]   den1_q;

	logic                out_valid_q;
	logic [MEAN_W-1:0]   win_out_q;
	logic [MEAN_W-1:0]   tot_out_q;
	logic                warm_out_q;

	logic                accept;
	logic                flush;
	logic                push;
	logic                start;
	logic                load_out;
	logic                busy_a;
	logic                busy_b;
	logic [FILL_W-1:0]   w_eff;
	logic [TOTAL_W-1:0]  win_total;
	logic [FILL_W-1:0]   win_fill;
	logic [DIV_NW-1:0]   quot_a;
	logic [DIV_NW-1:0]   quot_b;
	logic [DIV_NW-1:0]   num2;
	logic [DIV_DW-1:0]   den2;
	logic [N_W-1:0]      n_sum;
	logic [N_W-1:0]      div_n;
	logic [MEAN_W-1:0]   target;
	logic [MEAN_W-1:0]   mag;
	logic [DIV_NW-1:0]   up_sum;
	logic [MEAN_W-1:0]   new_mean;
	logic [MEAN_W-1:0]   win_mean;
	logic [MEAN_W-1:0]   win_sel;

	assign w_eff  = (window_size_q > FILL_W'(MAX_WINDOW)) ? FILL_W'(MAX_WINDOW) : window_size_q;
	assign accept = samples.valid && samples.ready;
	assign flush  = cfg_we && (cfg_index == REG_WINDOW_SIZE);
	assign n_sum  = N_W'(samples.expanded_count) + N_W'(count_offset_q);

	// settings
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_size_q  <= '0;
			count_offset_q <= '0;
			running_mean_q <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_WINDOW_SIZE:  window_size_q  <= cfg_data[FILL_W-1:0];
					REG_COUNT_OFFSET: count_offset_q <= cfg_data[OFFSET_W-1:0];
					REG_INITIAL_MEAN: running_mean_q <= cfg_data[MEAN_W-1:0];
					default: ;
				endcase
			end
			if (load_out) begin
				running_mean_q <= new_mean;
			end
		end
	end

	// sample capture and mean-update operands
	assign div_n  = (n_q == '0) ? N_W'(1) : n_q;
	assign target = {delay_q, 16'h0000};
	assign mag    = (target >= running_mean_q) ? target - running_mean_q
		: running_mean_q - target;

	always_ff @(posedge clk) begin
		if (accept) begin
			delay_q <= samples.delay_sample;
			n_q     <= n_sum;
			warm_q  <= n_sum < N_W'(2);
		end
		if (state_q == ST_PUSH) begin
			up_q   <= target >= running_mean_q;
			num1_q <= {1'b0, mag, 1'b0} + DIV_DW'(div_n);
			den1_q <= {div_n, 1'b0};
		end
	end

	// controller
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d        = state_q;
		samples.ready  = 1'b0;
		push           = 1'b0;
		start          = 1'b0;
		load_out       = 1'b0;
		case (state_q)
			ST_IDLE: begin
				samples.ready = 1'b1;
				if (samples.valid) state_d = ST_PUSH;
			end
			ST_PUSH: begin
				push    = w_eff != '0;
				state_d = ST_START;
			end
			ST_START: begin
				start   = 1'b1;
				state_d = ST_DIV;
			end
			ST_DIV: begin
				if (!busy_a && !busy_b) state_d = ST_FIN;
			end
			ST_FIN: begin
				if (!out_valid_q || means.ready) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	drwm_window u_window (
		.clk    (clk),
		.arst_n (arst_n),
		.flush  (flush),
		.push   (push),
		.wsize  (w_eff),
		.delay  (delay_q),
		.total  (win_total),
		.fill   (win_fill)
	);

	assign num2 = DIV_NW'({win_total, 17'h00000}) | DIV_NW'(win_fill);
	assign den2 = DIV_DW'({win_fill, 1'b0});

	drwm_div u_div_mean (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.num    (DIV_NW'(num1_q)),
		.den    (den1_q),
		.busy   (busy_a),
		.quot   (quot_a)
	);

	drwm_div u_div_window (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.num    (num2),
		.den    (den2),
		.busy   (busy_b),
		.quot   (quot_b)
	);

	// finish: apply rounded step, saturate, select outputs
	assign up_sum = DIV_NW'(running_mean_q) + quot_a;

	always_comb begin
		if (up_q) begin
			new_mean = (up_sum[DIV_NW-1:MEAN_W] != '0) ? MEAN_MAX : up_sum[MEAN_W-1:0];
		end else if (quot_a > DIV_NW'(running_mean_q)) begin
			new_mean = '0;
		end else begin
			new_mean = running_mean_q - quot_a[MEAN_W-1:0];
		end
	end

	assign win_mean = (quot_b[DIV_NW-1:MEAN_W] != '0) ? MEAN_MAX : quot_b[MEAN_W-1:0];
	assign win_sel  = (w_eff != '0 && win_fill != '0) ? win_mean : new_mean;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (means.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			win_out_q  <= warm_q ? MEAN_ONE : win_sel;
			tot_out_q  <= warm_q ? MEAN_ONE : new_mean;
			warm_out_q <= warm_q;
		end
	end

	assign means.valid       = out_valid_q;
	assign means.window_mean = win_out_q;
	assign means.total_mean  = tot_out_q;
	assign means.warming_up  = warm_out_q;

endmodule

// ===== rtl/drwm_checker.sv =====
// drwm_checker: port-level assertions for delay_running_and_window_mean
// depends on drwm_pkg; attached to the top level by the bind below
module drwm_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           in_valid,
	input logic                           in_ready,
	input logic                           out_valid,
	input logic                           out_ready,
	input logic [drwm_pkg::MEAN_W-1:0]    window_mean,
	input logic [drwm_pkg::MEAN_W-1:0]    total_mean,
	input logic                           warming_up
);
	import drwm_pkg::*;

	// warm-up beats carry 1.0 on both means
	a_warm_one: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && warming_up |-> window_mean == MEAN_ONE && total_mean == MEAN_ONE)
		else $error("warm-up beat without unit means");

	// one sample in flight: ready drops after a sample beat
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("sample accepted while busy");

	// the serial divide keeps the block busy: ready is still low when the dividers start
	a_busy_span: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> ##1 !in_ready)
		else $error("sample finished too early");

	// a stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(total_mean) && $stable(window_mean))
		else $error("result beat changed under stall");

endmodule

bind delay_running_and_window_mean drwm_checker u_drwm_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (samples.valid),
	.in_ready    (samples.ready),
	.out_valid   (means.valid),
	.out_ready   (means.ready),
	.window_mean (means.window_mean),
	.total_mean  (means.total_mean),
	.warming_up  (means.warming_up)
);

// ===== test/tb_delay_running_and_window_mean.sv =====
// tb_delay_running_and_window_mean: self-checking bench for the delay running and window mean
// block; a scoreboard class predicts every result beat and checks it on arrival
// depends on drwm_pkg, drwm_if and the rtl of delay_running_and_window_mean
module tb_delay_running_and_window_mean;
	import drwm_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
	localparam int unsigned CYCLE_LIMIT = 1_000_000;
	localparam int unsigned SAMPLE_TARGET = 1900;

	typedef struct {
		logic [MEAN_W-1:0] window_mean;
		logic [MEAN_W-1:0] total_mean;
		logic              warming_up;
	} mean_beat_t;

	class mean_scoreboard;
		bit [6:0]            win_size;
		bit [OFFSET_W-1:0]   offset;
		bit [MEAN_W-1:0]     running_mean;
		bit [SAMPLE_W-1:0]   recent_delays[MAX_WINDOW];
		int unsigned         win_total;
		int unsigned         fill;
		int unsigned         oldest;
		mean_beat_t          expected_means[$];
		int unsigned         errors;
		int unsigned         matched;

		function void write_reg(bit [CFG_IDX_W-1:0] idx, bit [CFG_DATA_W-1:0] data);
			case (idx)
				REG_WINDOW_SIZE: begin
					win_size = data[6:0];
					win_total = 0;
					fill = 0;
					oldest = 0;
				end
				REG_COUNT_OFFSET: offset = data[OFFSET_W-1:0];
				REG_INITIAL_MEAN: running_mean = data;
				default: ;
			endcase
		endfunction

		function void note_sample(bit [SAMPLE_W-1:0] delay, bit [COUNT_W-1:0] count);
			bit [63:0] n, div, target, mag, q, avg, num, win;
			int unsigned w, slot;
			bit warm;
			mean_beat_t beat;
			n = 64'(count) + 64'(offset);
			div = (n == 0) ? 64'd1 : n;
			target = 64'(delay) << 16;
			avg = 64'(running_mean);
			warm = (n < 64'd2);
			if (target >= avg) begin
				mag = target - avg;
				q = (64'd2 * mag + div) / (64'd2 * div);
				avg = avg + q;
			end else begin
				mag = avg - target;
				q = (64'd2 * mag + div) / (64'd2 * div);
				avg = (q > avg) ? 64'd0 : avg - q;
			end
			if (avg > 64'hFFFF_FFFF)
				avg = 64'hFFFF_FFFF;
			running_mean = avg[31:0];

			w = (win_size > MAX_WINDOW) ? MAX_WINDOW : win_size;
			if (w != 0) begin
				if (fill < w) begin
					slot = oldest + fill;
					if (slot >= w)
						slot -= w;
					recent_delays[slot] = delay;
					win_total += delay;
					fill++;
				end else begin
					slot = oldest;
					win_total = win_total - recent_delays[slot] + delay;
					recent_delays[slot] = delay;
					slot++;
					oldest = (slot >= w) ? 0 : slot;
				end
			end

			if (w != 0 && fill != 0) begin
				num = 64'(win_total) << 16;
				win = (64'd2 * num + 64'(fill)) / (64'd2 * 64'(fill));
				if (win > 64'hFFFF_FFFF)
					win = 64'hFFFF_FFFF;
			end else begin
				win = 64'(running_mean);
			end
			beat.window_mean = warm ? MEAN_ONE : win[31:0];
			beat.total_mean = warm ? MEAN_ONE : running_mean;
			beat.warming_up = warm;
			expected_means.insert(expected_means.size(), beat);
		endfunction

		function void check(mean_beat_t got);
			mean_beat_t want;
			if (expected_means.size() == 0) begin
				$display("%0t: result beat with nothing expected: window %h total %h warm %b",
					$time, got.window_mean, got.total_mean, got.warming_up);
				errors++;
				return;
			end
			want = expected_means[0];
			expected_means.delete(0);
			matched++;
			if (got.window_mean !== want.window_mean) begin
				$display("%0t: window_mean expected %h actual %h", $time,
					want.window_mean, got.window_mean);
				errors++;
			end
			if (got.total_mean !== want.total_mean) begin
				$display("%0t: total_mean expected %h actual %h", $time,
					want.total_mean, got.total_mean);
				errors++;
			end
			if (got.warming_up !== want.warming_up) begin
				$display("%0t: warming_up expected %b actual %b", $time,
					want.warming_up, got.warming_up);
				errors++;
			end
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	drwm_in_if  samples_if ();
	drwm_out_if means_if ();

	delay_running_and_window_mean u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.samples   (samples_if),
		.means     (means_if),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	mean_scoreboard sb = new;
	mean_beat_t     seen;
	bit             calm;
	int unsigned    sent_count;
	int unsigned    cycle_count;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("DONE: errors detected");
		$finish;
	end

	always @(posedge clk) begin
		if (samples_if.valid && samples_if.ready)
			sb.note_sample(samples_if.delay_sample, samples_if.expanded_count);
		if (means_if.valid && means_if.ready) begin
			seen.window_mean = means_if.window_mean;
			seen.total_mean = means_if.total_mean;
			seen.warming_up = means_if.warming_up;
			sb.check(seen);
		end
	end

	function automatic int unsigned draw_gap();
		return calm ? 0 : $urandom_range(0, 7);
	endfunction

	function automatic logic [SAMPLE_W-1:0] draw_delay();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2, 3: return SAMPLE_W'($urandom_range(1, 100));
			default: return SAMPLE_W'($urandom);
		endcase
	endfunction

	// result side: random stalls between beats
	initial begin
		means_if.ready <= 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			int unsigned stall;
			stall = draw_gap();
			if (stall != 0) begin
				means_if.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			means_if.ready <= 1'b1;
			do @(posedge clk); while (!means_if.valid);
		end
	end

	task automatic send_sample(input logic [SAMPLE_W-1:0] delay, input logic [COUNT_W-1:0] count);
		int unsigned gap;
		gap = draw_gap();
		if (gap != 0) begin
			samples_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		samples_if.valid <= 1'b1;
		samples_if.delay_sample <= delay;
		samples_if.expanded_count <= count;
		do @(posedge clk); while (!samples_if.ready);
		sent_count++;
	endtask

	// caller lowers cfg_we after the last write of a group
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		sb.write_reg(idx, data);
	endtask

	task automatic drain();
		samples_if.valid <= 1'b0;
		while (sb.matched != sent_count) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic shuffle_settings();
		logic [6:0]          wsz;
		logic [OFFSET_W-1:0] off;
		logic [MEAN_W-1:0]   start_mean;
		logic [31:0]         noise;
		noise = $urandom;
		if ($urandom_range(0, 2) != 0) begin
			case ($urandom_range(0, 7))
				0: wsz = 7'd0;
				1: wsz = 7'd1;
				2: wsz = 7'd64;
				3: wsz = 7'($urandom_range(65, 127));
				default: wsz = 7'($urandom_range(2, 16));
			endcase
			write_reg(REG_WINDOW_SIZE, {noise[31:7], wsz});
		end
		if ($urandom_range(0, 1) != 0) begin
			case ($urandom_range(0, 5))
				0: off = '0;
				1: off = 24'd1;
				2: off = '1;
				3: off = 24'($urandom_range(0, 40));
				default: off = 24'($urandom);
			endcase
			write_reg(REG_COUNT_OFFSET, {noise[7:0], off});
		end
		if ($urandom_range(0, 1) != 0) begin
			case ($urandom_range(0, 4))
				0: start_mean = '0;
				1: start_mean = MEAN_MAX;
				2: start_mean = MEAN_ONE;
				default: start_mean = $urandom;
			endcase
			write_reg(REG_INITIAL_MEAN, start_mean);
		end
		if ($urandom_range(0, 9) == 0)
			write_reg(REG_UNUSED, $urandom);
		cfg_we <= 1'b0;
	endtask

	initial begin
		int unsigned len;
		logic [COUNT_W-1:0] base, count;
		sent_count = 0;
		calm = 1'b0;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		samples_if.valid <= 1'b0;
		samples_if.delay_sample <= '0;
		samples_if.expanded_count <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: no window, zero divisor, warm-up edge
		send_sample(16'd1, 32'd0);
		send_sample(16'hFFFF, 32'd1);
		send_sample(16'd0, 32'd2);
		send_sample(16'hFFFF, 32'hFFFF_FFFF);
		send_sample(16'h8000, 32'd3);
		drain();

		// short ring that wraps, largest offset and starting mean
		write_reg(REG_WINDOW_SIZE, 32'd3);
		write_reg(REG_COUNT_OFFSET, 32'h00FF_FFFF);
		write_reg(REG_INITIAL_MEAN, MEAN_MAX);
		cfg_we <= 1'b0;
		send_sample(16'd0, 32'hFFFF_FFFF);
		send_sample(16'hFFFF, 32'd5);
		send_sample(16'd1, 32'd6);
		send_sample(16'd2, 32'd7);
		send_sample(16'h9C40, 32'd8);
		send_sample(16'h5555, 32'd9);
		drain();

		// oversize window saturates, masked upper bits, unused index
		write_reg(REG_WINDOW_SIZE, 32'hFFFF_FFFF);
		write_reg(REG_COUNT_OFFSET, 32'hFF00_0001);
		write_reg(REG_INITIAL_MEAN, MEAN_ONE);
		write_reg(REG_UNUSED, 32'hA5A5_A5A5);
		cfg_we <= 1'b0;
		send_sample(16'd7, 32'd0);
		send_sample(16'h00FF, 32'd1);
		send_sample(16'hAAAA, 32'd2);
		send_sample(16'd3, 32'h7FFF_FFFF);
		drain();

		write_reg(REG_WINDOW_SIZE, 32'd1);
		write_reg(REG_COUNT_OFFSET, 32'd0);
		write_reg(REG_INITIAL_MEAN, 32'd0);
		cfg_we <= 1'b0;
		send_sample(16'hFFFF, 32'd0);
		send_sample(16'd0, 32'd0);
		send_sample(16'h1234, 32'd2);
		send_sample(16'hFFFF, 32'd3);
		drain();

		while (sent_count < SAMPLE_TARGET) begin
			calm = ($urandom_range(0, 3) == 0);
			shuffle_settings();
			len = $urandom_range(10, 120);
			case ($urandom_range(0, 3))
				0: base = '0;
				1: base = 32'($urandom_range(0, 3));
				2: base = $urandom;
				default: base = 32'hFFFF_FFF0 - 32'($urandom_range(0, 200));
			endcase
			for (int unsigned i = 0; i < len; i++) begin
				// mostly a growing expansion count, with some stray values
				case ($urandom_range(0, 15))
					0: count = '0;
					1: count = 32'd1;
					2: count = $urandom;
					default: count = base + i;
				endcase
				send_sample(draw_delay(), count);
			end
			drain();
		end

		repeat (60) @(posedge clk);
		if (sb.errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
